// ----- rtl/sha1sh_pkg.sv -----
// Shared constants and types for the SHA-1 stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package sha1sh_pkg;

	typedef logic [31:0] word_t;

	// Initial chaining values H0 to H4
	localparam word_t H_INIT [0:4] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	// Round constants, one per group of twenty rounds
	localparam word_t K_R0 = 32'h5A827999;
	localparam word_t K_R1 = 32'h6ED9EBA1;
	localparam word_t K_R2 = 32'h8F1BBCDC;
	localparam word_t K_R3 = 32'hCA62C1D6;

	// Round count and group boundaries
	localparam logic [6:0] RND_G1   = 7'd20;
	localparam logic [6:0] RND_G2   = 7'd40;
	localparam logic [6:0] RND_G3   = 7'd60;
	localparam logic [6:0] RND_LAST = 7'd79;

	// Padding marker byte
	localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

`default_nettype wire

// ----- rtl/sha1sh_if.sv -----
// Valid/ready channel interfaces for message bytes and digest words.
`timescale 1ns / 1ps
`default_nettype none

interface sha1sh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1sh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/sha1_stream_hasher_unit.sv -----
// SHA-1 stream hasher: byte-per-word input, five digest words per message.
// An input word is taken while idle; one that completes a 64-byte block then
// runs 80 rounds on the shared round unit plus one chaining update.
// End of message: 9 to 72 padding bytes, one per cycle outside compression,
// fill one or two blocks; then five digest words, one per cycle when taken.
// Reset (arst_n low, asynchronous) restores H0..H4 and clears count and fill.
`timescale 1ns / 1ps
`default_nettype none

module sha1_stream_hasher_unit
	import sha1sh_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	sha1sh_in_if.sink     msg,
	sha1sh_out_if.source  dig
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [6:0]  rnd_q;
	logic        ending_q;
	logic        mark_q;
	logic        lenph_q;
	logic [2:0]  len_idx_q;
	logic        last_blk_q;
	logic [2:0]  out_idx_q;
	word_t       ch_q [0:4];
	word_t       a_q, b_q, c_q, d_q, e_q;

	logic        acc;
	logic        push_en;
	logic [7:0]  push_byte;
	logic        blk_full;
	logic        len_start;
	logic [2:0]  len_sel;
	logic [7:0]  len_byte;
	logic        word_en;
	word_t       w_cur;
	word_t       t_new;
	word_t       h_new [0:4];

	assign msg.ready = (state_q == ST_IDLE);
	assign acc       = msg.valid && msg.ready;

	// Present the digest straight from the chaining words
	assign dig.valid       = (state_q == ST_OUT);
	assign dig.digest_word = ch_q[out_idx_q];
	assign dig.word_index  = out_idx_q;
	assign dig.last_word   = (out_idx_q == 3'd4);

	// Length bytes, most significant first
	assign len_sel   = 3'd7 - len_idx_q;
	assign len_byte  = bits_q[{len_sel, 3'b000} +: 8];
	assign len_start = mark_q && (lenph_q || (fill_q == 6'd56));

	// Choose the byte entering the block buffer
	always_comb begin
		push_en   = 1'b0;
		push_byte = msg.data_byte;
		case (state_q)
			ST_IDLE: begin
				push_en = acc && msg.has_byte;
			end
			ST_PAD: begin
				push_en = 1'b1;
				if (!mark_q) begin
					push_byte = PAD_MARK;
				end else if (len_start) begin
					push_byte = len_byte;
				end else begin
					push_byte = 8'h00;
				end
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	assign blk_full = push_en && (fill_q == 6'd63);
	assign word_en  = (state_q == ST_COMP);

	assign h_new[0] = ch_q[0] + a_q;
	assign h_new[1] = ch_q[1] + b_q;
	assign h_new[2] = ch_q[2] + c_q;
	assign h_new[3] = ch_q[3] + d_q;
	assign h_new[4] = ch_q[4] + e_q;

	sha1sh_sched u_sched (
		.clk      (clk),
		.byte_en  (push_en),
		.byte_val (push_byte),
		.word_en  (word_en),
		.w_cur    (w_cur)
	);

	sha1sh_round u_round (
		.rnd (rnd_q),
		.a   (a_q),
		.b   (b_q),
		.c   (c_q),
		.d   (d_q),
		.e   (e_q),
		.w   (w_cur),
		.t   (t_new)
	);

	// Sequence filling, padding, rounds, chaining update and digest output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			bits_q     <= '0;
			rnd_q      <= '0;
			ending_q   <= 1'b0;
			mark_q     <= 1'b0;
			lenph_q    <= 1'b0;
			len_idx_q  <= '0;
			last_blk_q <= 1'b0;
			out_idx_q  <= '0;
			for (int i = 0; i < 5; i++) begin
				ch_q[i] <= H_INIT[i];
			end
			a_q <= H_INIT[0];
			b_q <= H_INIT[1];
			c_q <= H_INIT[2];
			d_q <= H_INIT[3];
			e_q <= H_INIT[4];
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (msg.has_byte) begin
							bits_q <= bits_q + 64'd8;
						end
						ending_q <= msg.end_of_message;
						if (blk_full) begin
							state_q <= ST_COMP;
						end else if (msg.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (!mark_q) begin
						mark_q <= 1'b1;
					end else if (len_start) begin
						lenph_q   <= 1'b1;
						len_idx_q <= len_idx_q + 3'd1;
						if (len_idx_q == 3'd7) begin
							last_blk_q <= 1'b1;
						end
					end
					if (blk_full) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					a_q <= t_new;
					b_q <= a_q;
					c_q <= {b_q[1:0], b_q[31:2]};
					d_q <= c_q;
					e_q <= d_q;
					if (rnd_q == RND_LAST) begin
						rnd_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 5; i++) begin
						ch_q[i] <= h_new[i];
					end
					a_q <= h_new[0];
					b_q <= h_new[1];
					c_q <= h_new[2];
					d_q <= h_new[3];
					e_q <= h_new[4];
					if (last_blk_q) begin
						state_q <= ST_OUT;
					end else if (ending_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig.ready) begin
						if (out_idx_q == 3'd4) begin
							// Drop the message state and start afresh
							state_q    <= ST_IDLE;
							out_idx_q  <= '0;
							fill_q     <= '0;
							bits_q     <= '0;
							ending_q   <= 1'b0;
							mark_q     <= 1'b0;
							lenph_q    <= 1'b0;
							len_idx_q  <= '0;
							last_blk_q <= 1'b0;
							for (int i = 0; i < 5; i++) begin
								ch_q[i] <= H_INIT[i];
							end
							a_q <= H_INIT[0];
							b_q <= H_INIT[1];
							c_q <= H_INIT[2];
							d_q <= H_INIT[3];
							e_q <= H_INIT[4];
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sha1sh_sched.sv -----
// Block buffer and message schedule window as one 64-byte shift line.
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_sched
	import sha1sh_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       byte_en,
	input  wire logic [7:0] byte_val,
	input  wire logic       word_en,
	output word_t           w_cur
);

	// Word j of the window sits at bits [511-32j -: 32]; word 0 is the current W
	logic [511:0] buf_q;
	word_t        w_new;
	word_t        w_mix;

	// Next schedule word from taps 0, 2, 8 and 13
	assign w_mix = buf_q[511:480] ^ buf_q[447:416] ^ buf_q[255:224] ^ buf_q[95:64];
	assign w_new = {w_mix[30:0], w_mix[31]};
	assign w_cur = buf_q[511:480];

	// Shift in a byte while filling, a word per round while compressing
	always_ff @(posedge clk) begin
		if (word_en) begin
			buf_q <= {buf_q[479:0], w_new};
		end else if (byte_en) begin
			buf_q <= {buf_q[503:0], byte_val};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sha1sh_round.sv -----
// Shared SHA-1 round function: selects f and K by round and forms the new A.
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_round
	import sha1sh_pkg::*;
(
	input  wire logic [6:0] rnd,
	input  wire word_t      a,
	input  wire word_t      b,
	input  wire word_t      c,
	input  wire word_t      d,
	input  wire word_t      e,
	input  wire word_t      w,
	output word_t           t
);

	word_t f;
	word_t k;

	// Pick the boolean function and constant for this round group
	always_comb begin
		if (rnd < RND_G1) begin
			f = (b & c) | (~b & d);
			k = K_R0;
		end else if (rnd < RND_G2) begin
			f = b ^ c ^ d;
			k = K_R1;
		end else if (rnd < RND_G3) begin
			f = (b & c) | (b & d) | (c & d);
			k = K_R2;
		end else begin
			f = b ^ c ^ d;
			k = K_R3;
		end
	end

	assign t = {a[26:0], a[31:27]} + f + e + k + w;

endmodule

`default_nettype wire
